>>> hdl/oht_pkg.sv
// shared types and constants of the opcode hash table
// no dependencies; imported by every module of the block

package oht_pkg;

    // sizing
    localparam int BUCKETS   = 20;
    localparam int ENTRIES   = 64;
    localparam int KEY_CHARS = 6;

    localparam int KEY_W  = 8 * KEY_CHARS;
    localparam int OP_W   = 8;
    localparam int FMT_W  = 2;
    localparam int STAT_W = 2;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IDX_W  = $clog2(ENTRIES);
    // links and the fill count both must hold ENTRIES itself
    localparam int LINK_W = $clog2(ENTRIES + 1);

    // hash reduction: sum of characters modulo BUCKETS by reciprocal multiply
    localparam int SUM_W   = $clog2(255 * KEY_CHARS + 1);
    localparam int MOD_SH  = SUM_W + 8;
    localparam int RECIP_W = MOD_SH + 1;
    localparam int RECIP   = (1 << MOD_SH) / BUCKETS;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int REM_W   = SUM_W + 9;

    // stream packing
    localparam int S_DATA_W = ((KEY_W + OP_W + FMT_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OP_W + FMT_W + 7) / 8) * 8;

    // commands and status codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OP_W-1:0]  opcode;
        logic [FMT_W-1:0] format;
    } t_entry;

    // write and read requests toward the entry store
    typedef struct packed {
        logic              data_we;
        logic [IDX_W-1:0]  data_waddr;
        logic              next_we;
        logic [IDX_W-1:0]  next_waddr;
        logic [LINK_W-1:0] next_wdata;
        logic [IDX_W-1:0]  raddr;
    } t_store_req;

endpackage

>>> hdl/oht_hash.sv
// key normalization and bucket hash, three register stages
// depends on oht_pkg

module oht_hash
    import oht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_valid,
    output logic [KEY_W-1:0] o_key,
    output logic [BKT_W-1:0] o_bucket
);

    logic [KEY_W-1:0]  norm_key;
    logic [SUM_W-1:0]  norm_sum;
    logic [PROD_W-1:0] quot_prod;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem_fix;

    logic              r_v1, r_v2;
    logic [KEY_W-1:0]  r_key1, r_key2;
    logic [SUM_W-1:0]  r_sum1, r_sum2;
    logic [SUM_W-1:0]  r_quot;

    // keep the characters before the first zero byte
    always_comb begin
        logic alive;
        alive    = 1'b1;
        norm_key = '0;
        norm_sum = '0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            alive = alive && (i_key[8*i +: 8] != 8'd0);
            if (alive) begin
                norm_key[8*i +: 8] = i_key[8*i +: 8];
                norm_sum = norm_sum + SUM_W'(i_key[8*i +: 8]);
            end
        end
    end

    // quotient estimate is exact or one too small
    assign quot_prod = PROD_W'(r_sum1) * PROD_W'(RECIP);
    assign rem_raw   = REM_W'(r_sum2) - (REM_W'(r_quot) * REM_W'(BUCKETS));
    assign rem_fix   = (rem_raw >= REM_W'(BUCKETS)) ? rem_raw - REM_W'(BUCKETS) : rem_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            o_valid <= r_v2;
        end
        r_key1   <= norm_key;
        r_sum1   <= norm_sum;
        r_key2   <= r_key1;
        r_sum2   <= r_sum1;
        r_quot   <= SUM_W'(quot_prod >> MOD_SH);
        o_key    <= r_key2;
        o_bucket <= BKT_W'(rem_fix);
    end

endmodule

>>> hdl/oht_entry_store.sv
// entry store: data memory (key, opcode, format) and link memory
// depends on oht_pkg; one write port each, shared read address, registered read data

module oht_entry_store
    import oht_pkg::*;
(
    input  logic              i_clk,
    input  t_store_req        i_req,
    input  t_entry            i_wdata,
    output t_entry            o_rdata,
    output logic [LINK_W-1:0] o_rnext
);

    t_entry            mem_data [ENTRIES];
    logic [LINK_W-1:0] mem_next [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.data_we) begin
            mem_data[i_req.data_waddr] <= i_wdata;
        end
        o_rdata <= mem_data[i_req.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.next_we) begin
            mem_next[i_req.next_waddr] <= i_req.next_wdata;
        end
        o_rnext <= mem_next[i_req.raddr];
    end

endmodule

>>> hdl/opcode_hash_table.sv
// top level of the mnemonic-to-opcode chained hash table
// depends on oht_pkg, oht_hash, oht_entry_store
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tuser: cmd; tdata: key, opcode, format
//  m_axis    out        tvalid/tready           tuser: status; tdata: opcode, format
//
// an insert passes through the hash state and then the emit state, with a link state
// between them when it links onto an existing chain (extra write on the single
// link-memory port); a lookup walks the chain in the look state, comparing
// one chain entry per cycle as each registered entry-store read returns.
// reset clears the bucket used bits, the fill count and the control state.
// the input is taken again once the previous item reaches the output register;
// a result waits in the emit state while the output register is still occupied.

module opcode_hash_table
    import oht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // key[47:0], opcode_in, format_in, zero pad
    input  logic                i_s_axis_tuser,   // cmd
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // opcode_out, format_out, zero pad
    output logic [STAT_W-1:0]   o_m_axis_tuser    // status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_LINK,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state r_state;

    // latched command
    logic             r_cmd;
    logic [OP_W-1:0]  r_op_in;
    logic [FMT_W-1:0] r_fmt_in;
    logic [KEY_W-1:0] r_key;

    // bucket table: used bits reset, head and tail written before use
    logic             r_used [BUCKETS];
    logic [IDX_W-1:0] r_head [BUCKETS];
    logic [IDX_W-1:0] r_tail [BUCKETS];

    logic [LINK_W-1:0] r_count;
    logic [LINK_W-1:0] r_steps;
    logic [IDX_W-1:0]  r_link_addr;
    logic [IDX_W-1:0]  r_new_idx;

    // pending result
    logic [STAT_W-1:0] r_res_stat;
    logic [OP_W-1:0]   r_res_op;
    logic [FMT_W-1:0]  r_res_fmt;

    // output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_stat;
    logic [OP_W-1:0]   r_out_op;
    logic [FMT_W-1:0]  r_out_fmt;

    logic              in_xact;
    logic              h_valid;
    logic [KEY_W-1:0]  h_key;
    logic [BKT_W-1:0]  h_bucket;
    logic              store_full;
    logic [IDX_W-1:0]  new_idx;
    logic              key_hit;
    logic              walk_on;
    logic              out_free;

    t_store_req        st_req;
    t_entry            st_wdata;
    t_entry            st_rdata;
    logic [LINK_W-1:0] st_rnext;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xact         = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_stat;
    assign o_m_axis_tdata  = M_DATA_W'({r_out_fmt, r_out_op});

    oht_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_xact),
        .i_key    (i_s_axis_tdata[KEY_W-1:0]),
        .o_valid  (h_valid),
        .o_key    (h_key),
        .o_bucket (h_bucket)
    );

    oht_entry_store u_store (
        .i_clk   (i_clk),
        .i_req   (st_req),
        .i_wdata (st_wdata),
        .o_rdata (st_rdata),
        .o_rnext (st_rnext)
    );

    assign store_full = (r_count == LINK_W'(ENTRIES));
    assign new_idx    = r_count[IDX_W-1:0];
    // chain walk: compare this entry, follow its link while it is valid and the step count stays below the fill count
    assign key_hit    = (st_rdata.key == r_key);
    assign walk_on    = (st_rnext < LINK_W'(ENTRIES))
                        && (LINK_W'(r_steps + LINK_W'(1)) < r_count);
    assign out_free   = !r_out_valid || i_m_axis_tready;

    assign st_wdata.key    = h_key;
    assign st_wdata.opcode = r_op_in;
    assign st_wdata.format = r_fmt_in;

    // memory requests
    always_comb begin
        st_req = '0;
        case (r_state)
            S_HASH: begin
                if (h_valid) begin
                    if (r_cmd == CMD_INSERT) begin
                        // new entry at the fill position, no successor yet
                        st_req.data_we    = !store_full;
                        st_req.data_waddr = new_idx;
                        st_req.next_we    = !store_full;
                        st_req.next_waddr = new_idx;
                        st_req.next_wdata = LINK_W'(ENTRIES);
                    end else begin
                        st_req.raddr = r_head[h_bucket];
                    end
                end
            end
            S_LINK: begin
                // old tail now points to the new entry
                st_req.next_we    = 1'b1;
                st_req.next_waddr = r_link_addr;
                st_req.next_wdata = LINK_W'(r_new_idx);
            end
            S_LOOK: begin
                st_req.raddr = st_rnext[IDX_W-1:0];
            end
            default: begin
                st_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            // in the emit state the output register is refilled or still held
            if (r_out_valid && i_m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        r_cmd    <= i_s_axis_tuser;
                        r_op_in  <= i_s_axis_tdata[KEY_W +: OP_W];
                        r_fmt_in <= i_s_axis_tdata[KEY_W+OP_W +: FMT_W];
                        r_state  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (h_valid) begin
                        r_key     <= h_key;
                        r_res_op  <= '0;
                        r_res_fmt <= '0;
                        if (r_cmd == CMD_INSERT) begin
                            if (store_full) begin
                                r_res_stat <= ST_FULL;
                                r_state    <= S_EMIT;
                            end else begin
                                r_res_stat       <= ST_OK;
                                r_used[h_bucket] <= 1'b1;
                                r_tail[h_bucket] <= new_idx;
                                r_count          <= LINK_W'(r_count + LINK_W'(1));
                                r_new_idx        <= new_idx;
                                r_link_addr      <= r_tail[h_bucket];
                                if (r_used[h_bucket]) begin
                                    r_state <= S_LINK;
                                end else begin
                                    r_head[h_bucket] <= new_idx;
                                    r_state          <= S_EMIT;
                                end
                            end
                        end else begin
                            r_steps <= '0;
                            if (r_used[h_bucket]) begin
                                r_state <= S_LOOK;
                            end else begin
                                r_res_stat <= ST_MISS;
                                r_state    <= S_EMIT;
                            end
                        end
                    end
                end
                S_LINK: begin
                    r_state <= S_EMIT;
                end
                S_LOOK: begin
                    if (key_hit) begin
                        r_res_stat <= ST_OK;
                        r_res_op   <= st_rdata.opcode;
                        r_res_fmt  <= st_rdata.format;
                        r_state    <= S_EMIT;
                    end else if (walk_on) begin
                        r_steps <= LINK_W'(r_steps + LINK_W'(1));
                    end else begin
                        r_res_stat <= ST_MISS;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_stat  <= r_res_stat;
                        r_out_op    <= r_res_op;
                        r_out_fmt   <= r_res_fmt;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
